// ===== design/argmax_confusion_matrix_accumulator_macros.svh =====
// Assertion macros for the checker file of the confusion-matrix block.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef ARGMAX_CONFUSION_MATRIX_ACCUMULATOR_MACROS_SVH
`define ARGMAX_CONFUSION_MATRIX_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACMA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACMA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/acma_pkg.sv =====
// Types and constants of the top-1 confusion-matrix accumulator.
// No dependencies; imported by every module of the block.
package acma_pkg;

	localparam logic [1:0] CMD_SCORE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] STAT_COUNTED = 2'd0;
	localparam logic [1:0] STAT_IGNORED = 2'd1;
	localparam logic [1:0] STAT_RANGE   = 2'd2;

	localparam logic KIND_CLASS = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 7;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IGNORE_ENABLE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IGNORE_LABEL  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_CLASSES   = 2'd2;

	localparam logic [6:0] NUM_CLASSES_RESET = 7'd64;

	typedef struct packed {
		logic [1:0]          cmd;
		logic signed [15:0]  score;
		logic [5:0]          true_label;
		logic                last_score;
		logic [5:0]          read_row;
		logic [5:0]          read_col;
	} request_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  predicted;
		logic        correct;
		logic [1:0]  status;
		logic [31:0] count_value;
	} result_t;

	// Outcome of a finished sample, from the argmax tracker to the counter path.
	typedef struct packed {
		logic [5:0] predicted;
		logic       correct;
		logic [1:0] status;
		logic       update;
	} sample_t;

endpackage

// ===== design/acma_argmax.sv =====
// Running top-1 argmax over the score stream and the label checks of a sample.
// Depends on acma_pkg.
module acma_argmax #(
	parameter int MAX_CLASSES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                score_en,
	input  logic signed [15:0]  score,
	input  logic [5:0]          true_label,
	input  logic                last_score,
	input  logic                ignore_enable,
	input  logic [5:0]          excluded_label,
	input  logic [6:0]          num_classes,
	output acma_pkg::sample_t   sample
);
	import acma_pkg::*;

	logic signed [15:0] best_score_q;
	logic [5:0]         best_index_q;
	logic [5:0]         elem_idx_q;
	logic               take;
	logic [5:0]         pred;
	logic               label_ok;
	logic               pred_ok;

	assign take = (elem_idx_q == 6'd0) || (score >= best_score_q);
	assign pred = take ? elem_idx_q : best_index_q;

	// Valid class means below both num_classes and the matrix size.
	assign label_ok = ({1'b0, true_label} < num_classes) && (int'(true_label) < MAX_CLASSES);
	assign pred_ok  = ({1'b0, pred} < num_classes) && (int'(pred) < MAX_CLASSES);

	always_comb begin
		sample.predicted = pred;
		sample.correct   = (pred == true_label);
		sample.update    = 1'b0;
		if (ignore_enable && (true_label == excluded_label)) begin
			sample.status = STAT_IGNORED;
		end else if (!label_ok || !pred_ok) begin
			sample.status = STAT_RANGE;
		end else begin
			sample.status = STAT_COUNTED;
			sample.update = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_index_q <= '0;
			elem_idx_q   <= '0;
		end else if (score_en) begin
			if (take) begin
				best_score_q <= score;
				best_index_q <= elem_idx_q;
			end
			// wrap after 64 elements, restart on the last one
			elem_idx_q <= last_score ? 6'd0 : elem_idx_q + 6'd1;
		end
	end

endmodule

// ===== design/argmax_confusion_matrix_accumulator.sv =====
// Top level of the top-1 confusion-matrix accumulator: argmax tracker plus
// counter memory with read-modify-write. Depends on acma_pkg and acma_argmax.
//
// Usage:
// - Request channel: a request is taken at a rising edge with start high and
//   busy low. cmd 0 streams one class score (ascending class order, true
//   label alongside, last_score on the final class); cmd 1 reads the counter
//   at (read_row, read_col); cmd 2 clears all counters; cmd 3 is dropped.
// - Result channel: done pulses for one cycle with the result struct. A
//   sample's last score or a read gives one result, via the modify stage
//   and the output register. The receiver cannot stall; results never wait.
// - Throughput: one request per cycle while busy is low. Back-to-back
//   updates and reads of the same counter are handled by forwarding the last
//   memory write into the modify stage.
// - Clear and reset: both start a sweep that writes zero to all
//   MAX_CLASSES*MAX_CLASSES counters (4096 at the default size), one per
//   cycle, with busy high until the sweep ends. A clear leaves a sample in
//   progress untouched. Configuration writes are taken at any time.
// - Counters saturate at all ones; count_value carries the low 32 bits.
module argmax_confusion_matrix_accumulator #(
	parameter int MAX_CLASSES = 64,
	parameter int COUNT_BITS  = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  acma_pkg::request_t                    request,
	output logic                                  done,
	output acma_pkg::result_t                     result,
	input  logic                                  cfg_we,
	input  logic [acma_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [acma_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import acma_pkg::*;

	localparam int DEPTH = MAX_CLASSES * MAX_CLASSES;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_SWEEP = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     sweep_addr_q;

	logic              ignore_enable_q;
	logic [5:0]        excluded_label_q;
	logic [6:0]        num_classes_q;

	logic              accept;
	logic              score_en;
	logic              read_en;
	sample_t           sample;

	logic [AW-1:0]     upd_addr;
	logic [AW-1:0]     read_addr;
	logic [AW-1:0]     rd_addr;
	logic              read_ok;

	logic [COUNT_BITS-1:0] count_mem_q [DEPTH];
	logic [COUNT_BITS-1:0] rd_data_s1;

	// modify stage
	logic              v_s1;
	logic              kind_s1;
	logic              upd_s1;
	logic              read_ok_s1;
	logic [AW-1:0]     addr_s1;
	logic [5:0]        pred_s1;
	logic              correct_s1;
	logic [1:0]        status_s1;

	// last memory write, for forwarding
	logic              wr_v_q;
	logic [AW-1:0]     wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [COUNT_BITS-1:0] mem_wd;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] inc;

	logic              done_q;
	result_t           result_q;

	assign busy     = (state_q == ST_SWEEP);
	assign accept   = start && !busy;
	assign score_en = accept && (request.cmd == CMD_SCORE);
	assign read_en  = accept && (request.cmd == CMD_READ);

	acma_argmax #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_argmax (
		.clk            (clk),
		.arst_n         (arst_n),
		.score_en       (score_en),
		.score          (request.score),
		.true_label     (request.true_label),
		.last_score     (request.last_score),
		.ignore_enable  (ignore_enable_q),
		.excluded_label (excluded_label_q),
		.num_classes    (num_classes_q),
		.sample         (sample)
	);

	// Row-major counter address; only used when row and column are in range.
	assign upd_addr  = AW'(request.true_label) * AW'(MAX_CLASSES) + AW'(sample.predicted);
	assign read_addr = AW'(request.read_row) * AW'(MAX_CLASSES) + AW'(request.read_col);
	assign read_ok   = (int'(request.read_row) < MAX_CLASSES) &&
	                   (int'(request.read_col) < MAX_CLASSES);
	assign rd_addr   = (request.cmd == CMD_READ) ? read_addr : upd_addr;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_enable_q  <= 1'b0;
			excluded_label_q <= '0;
			num_classes_q    <= NUM_CLASSES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IGNORE_ENABLE: ignore_enable_q  <= cfg_data[0];
				CFG_IGNORE_LABEL:  excluded_label_q <= cfg_data[5:0];
				CFG_NUM_CLASSES:   num_classes_q    <= cfg_data[6:0];
				default:           ;
			endcase
		end
	end

	// Sweep sequencer: zero every counter after reset and on a clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_addr_q <= '0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					if (sweep_addr_q == AW'(DEPTH - 1)) begin
						sweep_addr_q <= '0;
						state_q      <= ST_RUN;
					end else begin
						sweep_addr_q <= sweep_addr_q + AW'(1);
					end
				end
				ST_RUN: begin
					if (accept && (request.cmd == CMD_CLEAR)) begin
						sweep_addr_q <= '0;
						state_q      <= ST_SWEEP;
					end
				end
				default: begin
					sweep_addr_q <= '0;
					state_q      <= ST_SWEEP;
				end
			endcase
		end
	end

	// Counter memory: one read and one write port, registered read data.
	always_ff @(posedge clk) begin
		rd_data_s1 <= count_mem_q[rd_addr];
		if (mem_we) begin
			count_mem_q[mem_wa] <= mem_wd;
		end
	end

	// Take the previous write if it hit the entry this stage just read.
	assign cur = (wr_v_q && (wr_addr_q == addr_s1)) ? wr_data_q : rd_data_s1;
	assign inc = (&cur) ? cur : cur + COUNT_BITS'(1);

	assign mem_we = busy || (v_s1 && upd_s1);
	assign mem_wa = busy ? sweep_addr_q : addr_s1;
	assign mem_wd = busy ? '0 : inc;

	// Advance a request into the modify stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (score_en && request.last_score) || read_en;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1    <= read_en ? KIND_READ : KIND_CLASS;
		upd_s1     <= score_en && sample.update;
		read_ok_s1 <= read_ok;
		addr_s1    <= rd_addr;
		pred_s1    <= sample.predicted;
		correct_s1 <= sample.correct;
		status_s1  <= sample.status;
	end

	// Record the write just issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q <= 1'b0;
		end else begin
			wr_v_q <= mem_we;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= mem_wa;
		wr_data_q <= mem_wd;
	end

	// Output register: one-cycle strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_q.kind <= kind_s1;
		if (kind_s1 == KIND_READ) begin
			result_q.predicted   <= '0;
			result_q.correct     <= 1'b0;
			result_q.status      <= STAT_COUNTED;
			result_q.count_value <= read_ok_s1 ? 32'(cur) : 32'd0;
		end else begin
			result_q.predicted   <= pred_s1;
			result_q.correct     <= correct_s1;
			result_q.status      <= status_s1;
			result_q.count_value <= 32'd0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== design/acma_checker.sv =====
// Port-level checks of the confusion-matrix accumulator, bound to the top.
// Depends on acma_pkg and argmax_confusion_matrix_accumulator_macros.svh.
`include "argmax_confusion_matrix_accumulator_macros.svh"

module acma_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input acma_pkg::request_t request,
	input logic               done,
	input acma_pkg::result_t  result
);
	import acma_pkg::*;

	logic read_take;
	logic clear_take;
	logic read_done;

	assign read_take  = start && !busy && (request.cmd == CMD_READ);
	assign clear_take = start && !busy && (request.cmd == CMD_CLEAR);
	assign read_done  = done && (result.kind == KIND_READ);

	// A read that is taken always returns its data as a read result.
	`ACMA_ASSERT_IMP(a_read_latency, read_take, ##2 read_done, "read result missing")

	// Read data only ever answers a read that was taken.
	`ACMA_ASSERT_IMP(a_read_origin, read_done, $past(read_take, 2), "read result with no read")

	// A clear produces no result.
	`ACMA_ASSERT_IMP(a_clear_silent, clear_take, ##2 !done, "clear produced a result")

	// A clear starts the sweep at once.
	`ACMA_ASSERT_NXT(a_clear_busy, clear_take, busy, "clear did not raise busy")

endmodule

bind argmax_confusion_matrix_accumulator acma_checker u_acma_checker (.*);

// ===== sim/tb_argmax_confusion_matrix_accumulator.sv =====
// Self-checking testbench for the top-1 confusion-matrix accumulator.
// Drives a directed table, then random phases of samples, reads and clears; depends on acma_pkg and the block.
`timescale 1ns / 100ps

module tb_argmax_confusion_matrix_accumulator;
	import acma_pkg::*;

	localparam int CLASSES     = 64;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int SETTLE      = 4;      // idle margin after the last result
	localparam int STALL_LIMIT = 20000;  // must outlast a full clear sweep, during which busy stays high
	localparam logic [1:0] CMD_NONE = 2'd3;

	// Directed rows. For a score row a is the score, b the label, c[0] the last flag.
	// For a read row b and c are row and column. For a policy row a[0] is the
	// ignore enable, b the ignored label and c the class count.
	typedef enum logic [2:0] {DO_SCORE, DO_READ, DO_CLEAR, DO_NOP, DO_POLICY} drill_op_t;

	typedef struct packed {
		drill_op_t   op;
		logic [15:0] a;
		logic [6:0]  b;
		logic [6:0]  c;
		logic        typed;
		logic [5:0]  pred;
		logic        ok;
		logic [1:0]  status;
		logic [31:0] count;
	} drill_t;

	localparam int DRILL_ROWS = 27;
	localparam drill_t DRILL [0:DRILL_ROWS-1] = '{
		// counters read as zero after reset, both corners of the matrix
		'{DO_READ,   16'h0000, 7'd0,  7'd0,  1'b1, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_READ,   16'h0000, 7'd63, 7'd63, 1'b1, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		// one-element sample at the most negative score
		'{DO_SCORE,  16'h8000, 7'd0,  7'd1,  1'b1, 6'd0, 1'b1, STAT_COUNTED, 32'd0},
		// tie at the most positive score: the higher class wins
		'{DO_SCORE,  16'h7fff, 7'd1,  7'd0,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_SCORE,  16'h7fff, 7'd1,  7'd0,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_SCORE,  16'h8000, 7'd1,  7'd1,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_READ,   16'h0000, 7'd1,  7'd1,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		// negative first score is taken outright, top label row
		'{DO_SCORE,  16'hfffb, 7'd63, 7'd0,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_SCORE,  16'hfffd, 7'd63, 7'd1,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_READ,   16'h0000, 7'd63, 7'd1,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_NOP,    16'hffff, 7'd63, 7'd63, 1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		// clear in the middle of a sample keeps the running maximum
		'{DO_SCORE,  16'h0080, 7'd1,  7'd0,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_CLEAR,  16'h0000, 7'd0,  7'd0,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_SCORE,  16'h0100, 7'd1,  7'd1,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_READ,   16'h0000, 7'd0,  7'd0,  1'b1, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_READ,   16'h0000, 7'd1,  7'd1,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		// two classes: label out of range, then prediction out of range
		'{DO_POLICY, 16'h0000, 7'd0,  7'd2,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_SCORE,  16'h0000, 7'd2,  7'd1,  1'b1, 6'd0, 1'b0, STAT_RANGE,   32'd0},
		'{DO_SCORE,  16'h0001, 7'd0,  7'd0,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_SCORE,  16'h0002, 7'd0,  7'd0,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_SCORE,  16'h0003, 7'd0,  7'd1,  1'b1, 6'd2, 1'b0, STAT_RANGE,   32'd0},
		// ignore test wins over the range test
		'{DO_POLICY, 16'h0001, 7'd63, 7'd2,  1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_SCORE,  16'h0000, 7'd63, 7'd1,  1'b1, 6'd0, 1'b0, STAT_IGNORED, 32'd0},
		'{DO_READ,   16'h0000, 7'd63, 7'd0,  1'b1, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_POLICY, 16'h0001, 7'd0,  7'd64, 1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0},
		'{DO_SCORE,  16'h0000, 7'd0,  7'd1,  1'b1, 6'd0, 1'b1, STAT_IGNORED, 32'd0},
		'{DO_POLICY, 16'h0000, 7'd0,  7'd64, 1'b0, 6'd0, 1'b0, STAT_COUNTED, 32'd0}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	request_t                        request;
	logic                            done;
	result_t                         result;
	logic                            cfg_we;
	logic [CFG_IDX_BITS-1:0]         cfg_index;
	logic [CFG_DATA_BITS-1:0]        cfg_data;

	// Mirror of the block: running argmax, label policy and the counter matrix.
	logic signed [15:0] top_score;
	logic [5:0]         top_class;
	logic [5:0]         next_class;
	logic [31:0]        tally [0:CLASSES*CLASSES-1];
	bit [CLASSES*CLASSES-1:0] tally_live;
	logic               skip_en;
	logic [5:0]         skip_label;
	logic [6:0]         class_count;

	result_t pending_outcomes [$];
	int      faults;
	int      sent;
	int      idle_pct;
	int      stall_cycles;

	drill_t   row;
	request_t drill_req;
	result_t  drill_want;
	int       budget;
	int       pick;
	int       lanes;
	int       burst;

	argmax_confusion_matrix_accumulator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the mirror by one accepted request; return 1 when it yields a result.
	function automatic bit confusion_step(input request_t r, output result_t res);
		int         lim;
		logic [5:0] pred;
		logic [11:0] slot;
		logic [31:0] v;

		res = '0;
		case (r.cmd)
		CMD_SCORE: begin
			// first element of a sample takes the maximum outright; ties go to the later class
			if (next_class == 6'd0 || $signed(r.score) >= $signed(top_score)) begin
				top_score = r.score;
				top_class = next_class;
			end
			next_class = next_class + 6'd1;
			if (!r.last_score)
				return 1'b0;
			pred = top_class;
			next_class = 6'd0;
			lim = (class_count > CLASSES) ? CLASSES : class_count;
			res.kind = KIND_CLASS;
			res.predicted = pred;
			res.correct = (pred == r.true_label);
			if (skip_en && r.true_label == skip_label) begin
				res.status = STAT_IGNORED;
			end else if (r.true_label >= lim || pred >= lim) begin
				res.status = STAT_RANGE;
			end else begin
				slot = {r.true_label, pred};
				v = tally_live[slot] ? tally[slot] : '0;
				if (v != '1)
					v = v + 1;
				tally[slot] = v;
				tally_live[slot] = 1'b1;
				res.status = STAT_COUNTED;
			end
			return 1'b1;
		end
		CMD_READ: begin
			slot = {r.read_row, r.read_col};
			res.kind = KIND_READ;
			res.count_value = tally_live[slot] ? tally[slot] : '0;
			return 1'b1;
		end
		CMD_CLEAR: begin
			tally_live = '0;
			return 1'b0;
		end
		default: return 1'b0;
		endcase
	endfunction

	// Present one request, idling at random first; return at the falling edge after
	// it is taken, with start still high so a follow-on request can go back to back.
	task automatic issue(input request_t r, input bit typed, input result_t want);
		result_t calc;
		bit      yields;

		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		request <= r;
		do
			@(posedge clk);
		while (busy);
		yields = confusion_step(r, calc);
		if (yields)
			pending_outcomes.insert(pending_outcomes.size(), typed ? want : calc);
		if (r.cmd != CMD_NONE)
			sent++;
		@(negedge clk);
	endtask

	// Drain the block, then rewrite all three policy registers on successive edges.
	task automatic set_label_policy(input logic en, input logic [5:0] lbl,
			input logic [6:0] count);
		start <= 1'b0;
		@(negedge clk);
		while (pending_outcomes.size() != 0 || busy)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IGNORE_ENABLE;
		cfg_data <= {6'd0, en};
		@(negedge clk);
		cfg_index <= CFG_IGNORE_LABEL;
		cfg_data <= {1'b0, lbl};
		@(negedge clk);
		cfg_index <= CFG_NUM_CLASSES;
		cfg_data <= count;
		@(negedge clk);
		cfg_we <= 1'b0;
		skip_en = en;
		skip_label = lbl;
		class_count = count;
	endtask

	// Bias toward the extremes and toward tiny values so ties happen often.
	function automatic logic [15:0] draw_score();
		case ($urandom_range(0, 9))
		0: return 16'h7fff;
		1: return 16'h8000;
		2, 3: return 16'($urandom_range(0, 3));
		default: return 16'($urandom);
		endcase
	endfunction

	// Stream len scores; with steady clear, each element draws its own label, and with
	// finish clear the sample is left open for the next one to continue.
	task automatic send_sample(input int len, input logic [5:0] label, input bit steady,
			input bit finish);
		request_t r;
		result_t  none;

		none = '0;
		for (int i = 0; i < len; i++) begin
			r.cmd = CMD_SCORE;
			r.score = draw_score();
			r.true_label = steady ? label : 6'($urandom);
			r.last_score = finish && (i == len - 1);
			r.read_row = 6'($urandom);
			r.read_col = 6'($urandom);
			issue(r, 1'b0, none);
		end
	endtask

	function automatic logic [5:0] draw_class(input int lim);
		return ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, lim - 1)) : 6'($urandom);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			faults++;
		end
	endfunction

	// Compare each result strobe with the oldest outstanding expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, result);
				faults++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("kind", 32'(want.kind), 32'(result.kind));
				check_field("predicted", 32'(want.predicted), 32'(result.predicted));
				check_field("correct", 32'(want.correct), 32'(result.correct));
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("count_value", want.count_value, result.count_value);
			end
		end
	end

	// Watchdog: any taken request or any result restarts the count.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start <= 1'b0;
		request <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_IGNORE_ENABLE;
		cfg_data <= '0;
		sent = 0;
		idle_pct = 18;
		top_score = '0;
		top_class = '0;
		next_class = '0;
		tally_live = '0;
		skip_en = 1'b0;
		skip_label = '0;
		class_count = NUM_CLASSES_RESET;

		// hold reset, then release; the block then sweeps its counters with busy high
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed table: typed rows carry their own expectation, the rest use the mirror
		for (int i = 0; i < DRILL_ROWS; i++) begin
			row = DRILL[i];
			if (row.op == DO_POLICY) begin
				set_label_policy(row.a[0], row.b[5:0], row.c);
			end else begin
				case (row.op)
				DO_SCORE: drill_req.cmd = CMD_SCORE;
				DO_READ:  drill_req.cmd = CMD_READ;
				DO_CLEAR: drill_req.cmd = CMD_CLEAR;
				default:  drill_req.cmd = CMD_NONE;
				endcase
				drill_req.score = row.a;
				drill_req.true_label = row.b[5:0];
				drill_req.last_score = row.c[0];
				drill_req.read_row = row.b[5:0];
				drill_req.read_col = row.c[5:0];
				drill_want = '0;
				drill_want.kind = (row.op == DO_READ) ? KIND_READ : KIND_CLASS;
				drill_want.predicted = row.pred;
				drill_want.correct = row.ok;
				drill_want.status = row.status;
				drill_want.count_value = row.count;
				issue(drill_req, row.typed, drill_want);
			end
		end

		// random phases: new label policy per phase, sender idling set per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: set_label_policy(1'b0, 6'd0, 7'd64);
			1: set_label_policy(1'b1, 6'd63, 7'd2);
			2: set_label_policy(1'b1, 6'($urandom), 7'($urandom_range(2, 64)));
			3: set_label_policy(1'b0, 6'($urandom), 7'd64);
			4: set_label_policy(1'b1, 6'd0, 7'($urandom_range(2, 8)));
			default: set_label_policy(1'b1, 6'($urandom), 7'd63);
			endcase
			idle_pct = (ph < 2) ? 18 : (ph < 4) ? 74 : 0;
			lanes = class_count;
			budget = sent + PHASE_ITEMS;
			while (sent < budget) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					// well-formed sample: one score per class in use
					case ($urandom_range(0, 9))
					7: drill_req.true_label = skip_label;
					8, 9: drill_req.true_label = 6'($urandom);
					default: drill_req.true_label = 6'($urandom_range(0, lanes - 1));
					endcase
					send_sample(lanes, drill_req.true_label, 1'b1, 1'b1);
				end else if (pick < 67) begin
					// odd length, possibly past 64 elements so the class index wraps
					send_sample($urandom_range(1, 70), 6'd0, 1'b0, 1'b1);
				end else if (pick < 70) begin
					// broken sample with no last flag; the next one carries on from it
					send_sample($urandom_range(1, 5), 6'd0, 1'b0, 1'b0);
				end else if (pick < 94) begin
					burst = $urandom_range(1, 6);
					repeat (burst) begin
						drill_req = request_t'($urandom);
						drill_req.cmd = CMD_READ;
						drill_req.score = draw_score();
						drill_req.read_row = draw_class(lanes);
						drill_req.read_col = draw_class(lanes);
						issue(drill_req, 1'b0, '0);
					end
				end else if (pick < 97) begin
					drill_req = request_t'({$urandom, $urandom});
					drill_req.cmd = CMD_NONE;
					issue(drill_req, 1'b0, '0);
				end else begin
					drill_req = request_t'({$urandom, $urandom});
					drill_req.cmd = CMD_CLEAR;
					issue(drill_req, 1'b0, '0);
				end
			end
		end

		// drop start, wait out every outstanding result, then a short tail for strays
		start <= 1'b0;
		@(negedge clk);
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE * 3) @(negedge clk);
		if (faults == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/acma_pkg.sv
design/acma_argmax.sv
design/argmax_confusion_matrix_accumulator.sv
design/acma_checker.sv
sim/tb_argmax_confusion_matrix_accumulator.sv
